// ----- design/sac_pkg.sv -----
// Package: shared constants and types for the set-associative cache pair
`default_nettype none
package sac_pkg;
  localparam int NumSets    = 64;
  localparam int NumWays    = 4;
  localparam int BlockBytes = 32;
  localparam int AddrW      = 48;
  localparam int OffW       = $clog2(BlockBytes);
  localparam int SetW       = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int SetBits    = $clog2(NumSets);
  localparam int TagW       = AddrW - OffW - SetBits;
  localparam int WayW       = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int RankW      = 8;
  localparam int StampW     = 32;

  typedef enum logic [0:0] {
    PolicyFifo = 1'b0,
    PolicyLru  = 1'b1
  } policy_e;

  typedef enum logic [1:0] {
    StorePlain = 2'd0,
    StorePref  = 2'd1,
    StoreNext  = 2'd2
  } lookup_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        capture;   // latch a new request
    logic        read_set;  // read the set selected by sel
    logic        update;    // write back the set selected by sel
    lookup_sel_e sel;
  } sac_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pref_hit;
  } sac_sts_t;
endpackage
`default_nettype wire

// ----- design/sac_req_if.sv -----
// Interfaces: request and result channels
`default_nettype none
interface sac_req_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [sac_pkg::AddrW-1:0] access_address;
  modport source (output valid, req_type, access_address, input ready);
  modport sink (input valid, req_type, access_address, output ready);
endinterface

interface sac_rsp_if;
  logic       valid;
  logic       ready;
  logic       plain_hit;
  logic       plain_mem_reads;
  logic       prefetch_hit;
  logic [1:0] prefetch_mem_reads;
  logic       mem_writes;
  modport source (output valid, plain_hit, plain_mem_reads, prefetch_hit,
                  prefetch_mem_reads, mem_writes, input ready);
  modport sink (input valid, plain_hit, plain_mem_reads, prefetch_hit,
                prefetch_mem_reads, mem_writes, output ready);
endinterface
`default_nettype wire

// ----- design/sac_ctrl.sv -----
// Controller: sequences the lookups of one request
`default_nettype none
module sac_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     req_valid_i,
  output logic                    req_ready_o,
  output logic                    rsp_valid_o,
  input  wire                     rsp_ready_i,
  input  wire sac_pkg::sac_sts_t  sts_i,
  output sac_pkg::sac_cmd_t       cmd_o
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPlRd  = 7'b0000010,
    StPlWr  = 7'b0000100,
    StPfRd  = 7'b0001000,
    StPfWr  = 7'b0010000,
    StNxRd  = 7'b0100000,
    StNxWr  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   busy;

  assign busy        = (state_q != StIdle);
  assign req_ready_o = !busy && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;

  // Advance through plain, prefetch and next-block lookups
  always_comb begin
    state_d       = state_q;
    rsp_valid_d   = rsp_valid_q;
    cmd_o         = '0;
    cmd_o.sel     = sac_pkg::StorePlain;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.capture = 1'b1;
          state_d       = StPlRd;
        end
      end
      StPlRd: begin
        cmd_o.read_set = 1'b1;
        state_d        = StPlWr;
      end
      StPlWr: begin
        cmd_o.update = 1'b1;
        state_d      = StPfRd;
      end
      StPfRd: begin
        cmd_o.sel      = sac_pkg::StorePref;
        cmd_o.read_set = 1'b1;
        state_d        = StPfWr;
      end
      StPfWr: begin
        cmd_o.sel    = sac_pkg::StorePref;
        cmd_o.update = 1'b1;
        if (sts_i.pref_hit) begin
          rsp_valid_d = 1'b1;
          state_d     = StIdle;
        end else begin
          state_d = StNxRd;
        end
      end
      StNxRd: begin
        cmd_o.sel      = sac_pkg::StoreNext;
        cmd_o.read_set = 1'b1;
        state_d        = StNxWr;
      end
      StNxWr: begin
        cmd_o.sel    = sac_pkg::StoreNext;
        cmd_o.update = 1'b1;
        rsp_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/sac_dp.sv -----
// Datapath: tag stores, victim choice and result registers
`default_nettype none
module sac_dp (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire sac_pkg::sac_cmd_t         cmd_i,
  output sac_pkg::sac_sts_t              sts_o,
  input  wire                            policy_i,
  input  wire                            req_type_i,
  input  wire [sac_pkg::AddrW-1:0]       access_address_i,
  output logic                           plain_hit_o,
  output logic                           plain_mem_reads_o,
  output logic                           prefetch_hit_o,
  output logic [1:0]                     prefetch_mem_reads_o,
  output logic                           mem_writes_o
);
  localparam int Ways = sac_pkg::NumWays;
  localparam int Sets = sac_pkg::NumSets;

  typedef logic [sac_pkg::TagW-1:0]   tag_t;
  typedef logic [sac_pkg::RankW-1:0]  rank_t;
  typedef logic [sac_pkg::StampW-1:0] stamp_t;
  typedef logic [sac_pkg::SetW-1:0]   set_t;
  typedef logic [sac_pkg::WayW-1:0]   way_t;
  typedef logic [Ways-1:0]                      vld_row_t;
  typedef logic [Ways-1:0][sac_pkg::TagW-1:0]   tag_row_t;
  typedef logic [Ways-1:0][sac_pkg::RankW-1:0]  rank_row_t;
  typedef logic [Ways-1:0][sac_pkg::StampW-1:0] stamp_row_t;

  // One row per set; tags, ranks and stamps have no reset, valid bits do
  tag_row_t   pl_tag_mem   [Sets];
  tag_row_t   pf_tag_mem   [Sets];
  rank_row_t  pl_rank_mem  [Sets];
  rank_row_t  pf_rank_mem  [Sets];
  stamp_row_t pl_stamp_mem [Sets];
  stamp_row_t pf_stamp_mem [Sets];
  vld_row_t   pl_vld_q     [Sets];
  vld_row_t   pf_vld_q     [Sets];

  logic [sac_pkg::AddrW-1:0] addr_q;
  logic                      wr_q;
  stamp_t                    tick_q;
  logic                      pl_hit_q, pf_hit_q, nx_hit_q;

  // Lookup address and split
  logic [sac_pkg::AddrW-1:0] lk_addr;
  tag_t                      lk_tag;
  set_t                      lk_set;
  logic                      use_pref;
  assign use_pref = (cmd_i.sel != sac_pkg::StorePlain);
  assign lk_addr  = (cmd_i.sel == sac_pkg::StoreNext) ?
                    addr_q + sac_pkg::AddrW'(sac_pkg::BlockBytes) : addr_q;
  assign lk_tag   = lk_addr[sac_pkg::AddrW-1 -: sac_pkg::TagW];
  if (sac_pkg::SetBits > 0) begin : g_set
    assign lk_set = lk_addr[sac_pkg::OffW +: sac_pkg::SetW];
  end else begin : g_noset
    assign lk_set = '0;
  end

  // Registered read of the selected set row
  tag_row_t   rd_tag;
  vld_row_t   rd_vld;
  rank_row_t  rd_rank;
  stamp_row_t rd_stamp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_set) begin
      if (use_pref) begin
        rd_tag   <= pf_tag_mem[lk_set];
        rd_rank  <= pf_rank_mem[lk_set];
        rd_stamp <= pf_stamp_mem[lk_set];
        rd_vld   <= pf_vld_q[lk_set];
      end else begin
        rd_tag   <= pl_tag_mem[lk_set];
        rd_rank  <= pl_rank_mem[lk_set];
        rd_stamp <= pl_stamp_mem[lk_set];
        rd_vld   <= pl_vld_q[lk_set];
      end
    end
  end

  // Hit, fill and victim selection over the read set
  logic                  hit;
  way_t                  hit_way, inv_way, fifo_way, lru_way, tgt_way;
  logic                  any_inv, fifo_found, full;
  stamp_t                oldest;
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    any_inv    = 1'b0;
    inv_way    = '0;
    fifo_found = 1'b0;
    fifo_way   = '0;
    lru_way    = '0;
    oldest     = rd_stamp[0];
    for (int w = Ways - 1; w >= 0; w--) begin
      if (rd_vld[w] && rd_tag[w] == lk_tag) begin
        hit     = 1'b1;
        hit_way = way_t'(w);
      end
      if (!rd_vld[w]) begin
        any_inv = 1'b1;
        inv_way = way_t'(w);
      end
      if (rd_rank[w] == rank_t'(1)) begin
        fifo_found = 1'b1;
        fifo_way   = way_t'(w);
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (rd_stamp[w] < oldest) begin
        oldest  = rd_stamp[w];
        lru_way = way_t'(w);
      end
    end
    full = !hit && !any_inv;
    if (hit) tgt_way = hit_way;
    else if (any_inv) tgt_way = inv_way;
    else if (policy_i == sac_pkg::PolicyFifo) tgt_way = fifo_found ? fifo_way : '0;
    else tgt_way = lru_way;
  end
  assign sts_o.pref_hit = hit;

  // Build the updated set row
  tag_row_t   wr_tag;
  vld_row_t   wr_vld;
  rank_row_t  wr_rank;
  stamp_row_t wr_stamp;
  always_comb begin
    wr_tag   = rd_tag;
    wr_vld   = rd_vld;
    wr_rank  = rd_rank;
    wr_stamp = rd_stamp;
    for (int w = 0; w < Ways; w++) begin
      if (way_t'(w) == tgt_way) begin
        if (!hit || cmd_i.sel != sac_pkg::StoreNext) wr_stamp[w] = tick_q;
        if (!hit) begin
          wr_tag[w] = lk_tag;
          wr_vld[w] = 1'b1;
        end
      end
      if (!hit) begin
        if (full) begin
          wr_rank[w] = (way_t'(w) == tgt_way) ? rank_t'(Ways) : rd_rank[w] - rank_t'(1);
        end else if (way_t'(w) == tgt_way) begin
          wr_rank[w] = rank_t'(w + 1);
        end
      end
    end
  end

  // Write back tags, ranks and stamps
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (use_pref) begin
        pf_tag_mem[lk_set]   <= wr_tag;
        pf_rank_mem[lk_set]  <= wr_rank;
        pf_stamp_mem[lk_set] <= wr_stamp;
      end else begin
        pl_tag_mem[lk_set]   <= wr_tag;
        pl_rank_mem[lk_set]  <= wr_rank;
        pl_stamp_mem[lk_set] <= wr_stamp;
      end
    end
  end

  // Write back valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Sets; s++) begin
        pl_vld_q[s] <= '0;
        pf_vld_q[s] <= '0;
      end
    end else if (cmd_i.update) begin
      if (use_pref) pf_vld_q[lk_set] <= wr_vld;
      else          pl_vld_q[lk_set] <= wr_vld;
    end
  end

  // Request capture, saturating tick and hit flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= access_address_i;
      wr_q   <= req_type_i;
    end
    if (cmd_i.update) begin
      unique case (cmd_i.sel)
        sac_pkg::StorePlain: pl_hit_q <= hit;
        sac_pkg::StorePref:  pf_hit_q <= hit;
        sac_pkg::StoreNext:  nx_hit_q <= hit;
        default:             nx_hit_q <= hit;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_q <= '0;
    else if (cmd_i.capture && tick_q != '1) tick_q <= tick_q + stamp_t'(1);
  end

  assign plain_hit_o          = pl_hit_q;
  assign plain_mem_reads_o    = !pl_hit_q;
  assign prefetch_hit_o       = pf_hit_q;
  assign prefetch_mem_reads_o = pf_hit_q ? 2'd0 : (nx_hit_q ? 2'd1 : 2'd2);
  assign mem_writes_o         = wr_q;
endmodule
`default_nettype wire

// ----- design/set_assoc_cache_with_next_line_prefetch_core.sv -----
// Top level: cache pair with next-line prefetch
`default_nettype none
// Each request is accepted, then gets one set read and one set write-back per
// lookup through the single port of each tag store; the next-block lookup runs
// only when the prefetching store misses. The result is held in an output
// register and the next request is accepted once it is taken or as it is taken.
module set_assoc_cache_with_next_line_prefetch_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_wdata_i,
  sac_req_if.sink    req,
  sac_rsp_if.source  rsp
);
  sac_pkg::sac_cmd_t cmd;
  sac_pkg::sac_sts_t sts;
  logic              policy_q;

  // Hold the replacement policy register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) policy_q <= sac_pkg::PolicyLru;
    else if (cfg_we_i) policy_q <= cfg_wdata_i;
  end

  sac_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sac_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i                (cmd),
    .sts_o                (sts),
    .policy_i             (policy_q),
    .req_type_i           (req.req_type),
    .access_address_i     (req.access_address),
    .plain_hit_o          (rsp.plain_hit),
    .plain_mem_reads_o    (rsp.plain_mem_reads),
    .prefetch_hit_o       (rsp.prefetch_hit),
    .prefetch_mem_reads_o (rsp.prefetch_mem_reads),
    .mem_writes_o         (rsp.mem_writes)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready) else $error("accept while busy");
  a_mem_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.prefetch_hit == (rsp.prefetch_mem_reads == 2'd0)))
    else $error("prefetch read count mismatch");
  a_plain_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.plain_hit != rsp.plain_mem_reads))
    else $error("plain read count mismatch");
endmodule
`default_nettype wire
